/* hw/rtl/ffba_pkg.sv */
// Shared types and constants of the first-fit block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffba_pkg;

    // Field widths fixed by the request and result formats
    localparam int SIZE_W = 17;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_ENTRIES = 32;
    localparam int DEF_ADDR_BITS     = 16;

    // Managed memory size after reset
    localparam logic [SIZE_W-1:0] MEM_BYTES_RESET = 17'h10000;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOGAP    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTALLOC = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    accept;       // latch request, start ascending read stream
        logic    read_step;    // issue the next table read
        logic    alloc_eval;   // fold the read entry into the gap search
        logic    desc_start;   // start descending read stream for insertion
        logic    shift_up;     // move read entry one slot up
        logic    place;        // write new entry and commit allocation
        logic    free_eval;    // compare read entry against the free address
        logic    shift_down;   // move read entry one slot down
        logic    free_commit;  // commit removal
        logic    set_err;      // record an error result
        status_t err_code;
        logic    out_load;     // load the result beat register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rd_vld;    // read data valid this cycle
        logic fit;       // gap before read entry takes the request
        logic last;      // read entry is the last table entry
        logic place_ok;  // request fits at the running end address
        logic gt;        // read entry starts above the new block
        logic match;     // read entry starts at the free address
        logic full;
        logic empty;
        logic rd_done;   // no reads left to issue
    } dp_stat_t;

endpackage

/* hw/rtl/ffba_ctrl.sv */
// Request sequencer of the first-fit block allocator.
// Depends on ffba_pkg; drives datapath commands and the stream handshakes.
module ffba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                req_free,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ffba_pkg::dp_stat_t  stat,
    output ffba_pkg::ctl_cmd_t  cmd
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,
        S_TAIL,
        S_UP,
        S_PLACE,
        S_FSCAN,
        S_FSHIFT,
        S_FCOMMIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err_code = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    priority if (!req_free && stat.full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_FULL;
                        state_next   = S_FINISH;
                    end else if (!req_free && stat.empty) begin
                        state_next = S_TAIL;
                    end else if (!req_free) begin
                        state_next = S_ASCAN;
                    end else if (stat.empty) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_NOTALLOC;
                        state_next   = S_FINISH;
                    end else begin
                        state_next = S_FSCAN;
                    end
                end
            end
            S_ASCAN: begin
                cmd.read_step  = 1'b1;
                cmd.alloc_eval = 1'b1;
                if (stat.rd_vld && stat.fit) begin
                    cmd.desc_start = 1'b1;
                    state_next     = S_UP;
                end else if (stat.rd_vld && stat.last) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                if (stat.place_ok) begin
                    cmd.desc_start = 1'b1;
                    state_next     = S_UP;
                end else begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_NOGAP;
                    state_next   = S_FINISH;
                end
            end
            S_UP: begin
                cmd.read_step = 1'b1;
                cmd.shift_up  = 1'b1;
                if ((stat.rd_vld && !stat.gt) || (!stat.rd_vld && stat.rd_done)) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = S_FINISH;
            end
            S_FSCAN: begin
                cmd.read_step = 1'b1;
                cmd.free_eval = 1'b1;
                if (stat.rd_vld && stat.match) begin
                    state_next = stat.last ? S_FCOMMIT : S_FSHIFT;
                end else if (stat.rd_vld && stat.last) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_NOTALLOC;
                    state_next   = S_FINISH;
                end
            end
            S_FSHIFT: begin
                cmd.read_step  = 1'b1;
                cmd.shift_down = 1'b1;
                if (stat.rd_vld && stat.last) begin
                    state_next = S_FCOMMIT;
                end
            end
            S_FCOMMIT: begin
                cmd.free_commit = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* hw/rtl/ffba_datapath.sv */
// Block table, gap search and result registers of the first-fit allocator.
// Depends on ffba_pkg; acts on commands from ffba_ctrl and on config writes.
module ffba_datapath #(
    parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDR_BITS     = ffba_pkg::DEF_ADDR_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [ffba_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic [ffba_pkg::SIZE_W-1:0]   in_size,
    input  logic [ADDR_BITS-1:0]          in_addr,
    input  ffba_pkg::ctl_cmd_t            cmd,
    output ffba_pkg::dp_stat_t            stat,
    output ffba_pkg::status_t             out_status,
    output logic [ADDR_BITS-1:0]          out_addr,
    output logic [ffba_pkg::SIZE_W-1:0]   out_free
);
    import ffba_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;
    // Address span clipped to what the size field can hold
    localparam logic [SIZE_W:0] SPAN_CLIP = (ADDR_BITS >= SIZE_W) ?
        {1'b1, {SIZE_W{1'b0}}} : ((SIZE_W+1)'(1) << ADDR_BITS);

    // Block table
    logic [ADDR_BITS-1:0] start_mem [TABLE_ENTRIES];
    logic [SIZE_W-1:0]    len_mem   [TABLE_ENTRIES];

    logic [SIZE_W-1:0]    mem_bytes_reg;
    logic [CW-1:0]        count_reg;
    logic [SIZE_W-1:0]    used_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_BITS-1:0] faddr_reg;
    logic [EW-1:0]        prev_end_reg;
    logic [CW-1:0]        rd_ptr_reg;
    logic [CW-1:0]        rd_rem_reg;
    logic                 rd_dn_reg;
    logic                 rd_vld_reg;
    logic                 rd_vld_next;
    logic [CW-1:0]        rd_idx_reg;
    logic [ADDR_BITS-1:0] rd_start_reg;
    logic [SIZE_W-1:0]    rd_len_reg;
    logic [CW-1:0]        wr_ptr_reg;
    logic [SIZE_W-1:0]    flen_reg;
    status_t              res_status_reg;
    logic [ADDR_BITS-1:0] res_addr_reg;
    status_t              out_status_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [SIZE_W-1:0]    out_free_reg;

    logic [SIZE_W-1:0]    bound;
    logic [SIZE_W-1:0]    free_now;
    logic [EW:0]          p_plus;
    logic                 place_ok;
    logic                 fit;
    logic [EW-1:0]        end_val;
    logic [ADDR_BITS-1:0] new_start;
    logic                 gt;
    logic                 rd_fire;
    logic [CW-1:0]        rd_idx_m1;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic [ADDR_BITS-1:0] wr_start;
    logic [SIZE_W-1:0]    wr_len;

    // Placement bound and free byte count
    assign bound    = ({1'b0, mem_bytes_reg} < SPAN_CLIP) ? mem_bytes_reg
                                                          : SPAN_CLIP[SIZE_W-1:0];
    assign free_now = (bound > used_reg) ? (bound - used_reg) : '0;

    // Gap test at the running end address
    assign p_plus    = {1'b0, prev_end_reg} + (EW+1)'(size_reg);
    assign place_ok  = (prev_end_reg[EW-1:ADDR_BITS] == '0) && (p_plus <= (EW+1)'(bound));
    assign fit       = ((EW+1)'(rd_start_reg) >= p_plus) && place_ok;
    assign end_val   = EW'(rd_start_reg) + EW'(rd_len_reg);
    assign new_start = prev_end_reg[ADDR_BITS-1:0];
    assign gt        = rd_start_reg > new_start;
    assign rd_idx_m1 = rd_idx_reg - CW'(1);

    // Read stream control
    assign rd_fire     = cmd.read_step && (rd_rem_reg != '0);
    assign rd_vld_next = rd_fire && !cmd.desc_start && !cmd.accept;

    // Status toward the controller
    always_comb begin
        stat          = '0;
        stat.rd_vld   = rd_vld_reg;
        stat.fit      = fit;
        stat.last     = (rd_idx_reg == count_reg - CW'(1));
        stat.place_ok = place_ok;
        stat.gt       = gt;
        stat.match    = (rd_start_reg == faddr_reg);
        stat.full     = (count_reg == CW'(TABLE_ENTRIES));
        stat.empty    = (count_reg == '0);
        stat.rd_done  = (rd_rem_reg == '0);
    end

    // Select the single table write of this cycle
    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = '0;
        wr_start = rd_start_reg;
        wr_len   = rd_len_reg;
        if (cmd.shift_up && rd_vld_reg && gt) begin
            wr_en  = 1'b1;
            wr_idx = wr_ptr_reg[IW-1:0];
        end else if (cmd.shift_down && rd_vld_reg) begin
            wr_en  = 1'b1;
            wr_idx = rd_idx_m1[IW-1:0];
        end else if (cmd.place) begin
            wr_en    = 1'b1;
            wr_idx   = wr_ptr_reg[IW-1:0];
            wr_start = new_start;
            wr_len   = size_reg;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_idx] <= wr_start;
            len_mem[wr_idx]   <= wr_len;
        end
        if (rd_fire) begin
            rd_start_reg <= start_mem[rd_ptr_reg[IW-1:0]];
            rd_len_reg   <= len_mem[rd_ptr_reg[IW-1:0]];
            rd_idx_reg   <= rd_ptr_reg;
        end
    end

    // Control state: register, table fill, usage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_bytes_reg <= MEM_BYTES_RESET;
            count_reg     <= '0;
            used_reg      <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            if (cfg_wen) begin
                mem_bytes_reg <= cfg_wdata;
            end
            rd_vld_reg <= rd_vld_next;
            if (cmd.place) begin
                count_reg <= count_reg + CW'(1);
                used_reg  <= used_reg + size_reg;
            end else if (cmd.free_commit) begin
                count_reg <= count_reg - CW'(1);
                used_reg  <= (used_reg >= flen_reg) ? (used_reg - flen_reg) : '0;
            end
        end
    end

    // Read pointers: ascending from entry 0, or descending from the top entry
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_ptr_reg <= '0;
            rd_rem_reg <= count_reg;
            rd_dn_reg  <= 1'b0;
        end else if (cmd.desc_start) begin
            rd_ptr_reg <= count_reg - CW'(1);
            rd_rem_reg <= count_reg;
            rd_dn_reg  <= 1'b1;
        end else if (rd_fire) begin
            rd_ptr_reg <= rd_dn_reg ? (rd_ptr_reg - CW'(1)) : (rd_ptr_reg + CW'(1));
            rd_rem_reg <= rd_rem_reg - CW'(1);
        end
    end

    // Request, search and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            size_reg     <= in_size;
            faddr_reg    <= in_addr;
            prev_end_reg <= '0;
        end else if (cmd.alloc_eval && rd_vld_reg && !fit) begin
            prev_end_reg <= (end_val > prev_end_reg) ? end_val : prev_end_reg;
        end

        // Insertion slot walks down as entries move up
        if (cmd.desc_start) begin
            wr_ptr_reg <= count_reg;
        end else if (cmd.shift_up && rd_vld_reg && gt) begin
            wr_ptr_reg <= wr_ptr_reg - CW'(1);
        end

        if (cmd.free_eval && rd_vld_reg && stat.match) begin
            flen_reg <= rd_len_reg;
        end

        if (cmd.place) begin
            res_status_reg <= ST_OK;
            res_addr_reg   <= new_start;
        end else if (cmd.free_commit) begin
            res_status_reg <= ST_OK;
            res_addr_reg   <= faddr_reg;
        end else if (cmd.set_err) begin
            res_status_reg <= cmd.err_code;
            res_addr_reg   <= '0;
        end

        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_free_reg   <= free_now;
        end
    end

    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_free   = out_free_reg;

endmodule

/* hw/rtl/first_fit_block_allocator_unit.sv */
// Top level of the first-fit block allocator: stream ports and config register.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
//
//   Port group   Dir  Payload
//   s_*          in   tuser: req_type; tdata: alloc_size, free_address
//   m_*          out  tuser: status;   tdata: block_address, free_bytes
//   cfg_*        in   memory_bytes, written whenever cfg_wen is high
//
// One request at a time; the block table is read one entry per cycle through
// its single read port, so time per request grows with the table fill.
// A full-table or empty-table reject finishes without reading the table.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous; it empties the table and restores memory_bytes.
module first_fit_block_allocator_unit #(
    parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDR_BITS     = ffba_pkg::DEF_ADDR_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wen,
    input  logic [ffba_pkg::SIZE_W-1:0]                cfg_wdata,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // alloc_size, free_address (lowest bit up), zero padded
    input  logic [((ffba_pkg::SIZE_W+ADDR_BITS+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [0:0]                                 s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // block_address, free_bytes (lowest bit up), zero padded
    output logic [((ffba_pkg::SIZE_W+ADDR_BITS+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]                                 m_tuser
);
    import ffba_pkg::*;

    localparam int DATA_W = ((SIZE_W + ADDR_BITS + 7) / 8) * 8;

    ctl_cmd_t             ctl_cmd;
    dp_stat_t             ctl_stat;
    status_t              out_status;
    logic [ADDR_BITS-1:0] out_addr;
    logic [SIZE_W-1:0]    out_free;

    // Sequencer
    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_free (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    // Table and arithmetic
    ffba_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_size    (s_tdata[SIZE_W-1:0]),
        .in_addr    (s_tdata[SIZE_W +: ADDR_BITS]),
        .cmd        (ctl_cmd),
        .stat       (ctl_stat),
        .out_status (out_status),
        .out_addr   (out_addr),
        .out_free   (out_free)
    );

    // Pack the result beat
    assign m_tdata = DATA_W'({out_free, out_addr});
    assign m_tuser = out_status;

    // One request in flight: an accepted beat drops ready in the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Never place a block into a full table
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_stat.full |-> !ctl_cmd.place)
        else $error("insert into full block table");

    // A pending result beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result beat overwritten before taken");

    // A new result beat appears only after a result load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctl_cmd.out_load))
        else $error("result valid raised without a result load");

endmodule
